@@ hdl/eig_pkg.sv @@
// Shared widths, types and status codes for the 2x2 eigenvalue pipeline.
// Used by eig_div and eigen_2x2_closed_form; no dependencies.
package eig_pkg;

  localparam int FRAC_BITS = 8;
  localparam int IN_W      = 16;
  localparam int DIFF_W    = IN_W + 1;          // a-d, a+d
  localparam int ROOT_W    = IN_W + 1;          // floor(sqrt(disc))
  localparam int RAD_W     = 2 * ROOT_W;        // unsigned radicand
  localparam int DISC_W    = RAD_W + 1;         // signed discriminant
  localparam int REM_W     = ROOT_W + 2;        // root remainder
  localparam int NUM_W     = IN_W + 3;          // diff -/+ root
  localparam int LAM_W     = 18;
  localparam int VEC_W     = 24;
  localparam int DVS_W     = IN_W;              // |c|
  localparam int Q_W       = NUM_W - 2 + FRAC_BITS; // quotient magnitude bits
  localparam int DIV_LAT   = Q_W + 1;
  localparam int LATENCY   = 3 + ROOT_W + 1 + DIV_LAT;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_COMPLEX = 2'd1,
    ST_CZERO   = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  // fields that ride along the root pipeline
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] tr;
    logic                     neg;
    logic                     czero;
    logic signed [IN_W-1:0]   c;
  } root_side_t;

  // fields that ride along the divider
  typedef struct packed {
    logic signed [LAM_W-1:0] lo;
    logic signed [LAM_W-1:0] hi;
    logic                    neg;
    logic                    czero;
  } div_side_t;

endpackage

@@ hdl/eig_div.sv @@
// Pipelined signed divider: q = trunc(num * 2^FRAC_BITS / (2*den)), saturated.
// One restoring step per stage; depends on eig_pkg.
module eig_div (
  input  logic                               clk,
  input  logic signed [eig_pkg::NUM_W-1:0]   num,
  input  logic signed [eig_pkg::IN_W-1:0]    den,
  output logic signed [eig_pkg::VEC_W-1:0]   q,
  output logic                               sat
);

  localparam int QW = eig_pkg::Q_W;
  localparam int DW = eig_pkg::DVS_W;
  localparam int NW = eig_pkg::NUM_W;
  localparam int VW = eig_pkg::VEC_W;

  logic [QW-1:0] work_r [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] dvs_r  [QW];
  logic          sgn_r  [QW];

  logic [NW-1:0] num_abs;
  logic [DW-1:0] den_abs;
  logic [QW-1:0] dvd;

  always_comb begin
    num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    den_abs = den[DW-1] ? DW'(-den) : DW'(den);
    // 2^F / 2 folded into the dividend shift
    dvd     = {num_abs[NW-2:0], {(eig_pkg::FRAC_BITS-1){1'b0}}};
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [QW-1:0] w_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic          s_in;
    logic [DW:0]   r_try;
    logic          ge;

    if (i == 0) begin : g_first
      assign w_in = dvd;
      assign r_in = '0;
      assign d_in = den_abs;
      assign s_in = num[NW-1] ^ den[DW-1];
    end else begin : g_next
      assign w_in = work_r[i-1];
      assign r_in = rem_r[i-1];
      assign d_in = dvs_r[i-1];
      assign s_in = sgn_r[i-1];
    end

    assign r_try = {r_in, w_in[QW-1]};
    assign ge    = (r_try >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      work_r[i] <= {w_in[QW-2:0], ge};
      rem_r[i]  <= ge ? DW'(r_try - {1'b0, d_in}) : DW'(r_try);
      dvs_r[i]  <= d_in;
      sgn_r[i]  <= s_in;
    end
  end

  localparam logic signed [QW:0] VMAX = (QW+1)'((1 << (VW-1)) - 1);
  localparam logic signed [QW:0] VMIN = -(QW+1)'(1 << (VW-1));

  logic signed [QW:0] qs;
  logic signed [VW-1:0] q_nxt;
  logic sat_nxt;
  logic signed [VW-1:0] q_r;
  logic sat_r;

  always_comb begin
    qs = sgn_r[QW-1] ? -$signed({1'b0, work_r[QW-1]}) : $signed({1'b0, work_r[QW-1]});
    sat_nxt = 1'b0;
    if (qs > VMAX) begin
      q_nxt   = VMAX[VW-1:0];
      sat_nxt = 1'b1;
    end else if (qs < VMIN) begin
      q_nxt   = VMIN[VW-1:0];
      sat_nxt = 1'b1;
    end else begin
      q_nxt = qs[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign q   = q_r;
  assign sat = sat_r;

endmodule

@@ hdl/eigen_2x2_closed_form.sv @@
// Eigenvalues and eigenvector x-components of a 2x2 Q8.8 matrix.
// Uses eig_pkg and eig_div.
//
// Usage: drive the four entries on in_* and pulse start; busy is always low,
// so one word is taken every cycle that start is high. Each result appears
// on out_* for exactly one cycle, marked by out_valid, after the delay set by
// eig_pkg::LATENCY from the start that carried it. Throughput is one word per
// cycle with no gaps, results keep input order.
// The pipeline is three front stages (entry register, multiplies,
// discriminant), one stage per root bit (17), one stage to form the
// eigenvalues and numerators, and one stage per quotient bit (25) plus an
// output/saturate stage in the two parallel dividers.
// status: 0 ok, 1 complex (all values zero), 2 bottom_left zero (vectors
// zero), 3 a vector saturated.
// Reset clears all valid bits; words in flight are dropped and out_valid
// stays low until new words arrive. The receiver cannot stall, so nothing
// is held back.
module eigen_2x2_closed_form (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [eig_pkg::IN_W-1:0]   in_top_left,
  input  logic signed [eig_pkg::IN_W-1:0]   in_top_right,
  input  logic signed [eig_pkg::IN_W-1:0]   in_bottom_left,
  input  logic signed [eig_pkg::IN_W-1:0]   in_bottom_right,
  output logic                              out_valid,
  output logic signed [eig_pkg::LAM_W-1:0]  out_lambda_low,
  output logic signed [eig_pkg::LAM_W-1:0]  out_lambda_high,
  output logic signed [eig_pkg::VEC_W-1:0]  out_vector_low_x,
  output logic signed [eig_pkg::VEC_W-1:0]  out_vector_high_x,
  output logic [1:0]                        out_status
);

  localparam int IW = eig_pkg::IN_W;
  localparam int FW = eig_pkg::DIFF_W;
  localparam int RW = eig_pkg::ROOT_W;
  localparam int MW = eig_pkg::REM_W;
  localparam int AW = eig_pkg::RAD_W;
  localparam int XW = eig_pkg::DISC_W;
  localparam int NW = eig_pkg::NUM_W;
  localparam int LW = eig_pkg::LAM_W;
  localparam int DL = eig_pkg::DIV_LAT;

  assign busy = 1'b0;

  // ---- stage 0: entry register
  logic                 v0_r;
  logic signed [IW-1:0] a0_r, b0_r, c0_r, d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    a0_r <= in_top_left;
    b0_r <= in_top_right;
    c0_r <= in_bottom_left;
    d0_r <= in_bottom_right;
  end

  // ---- stage 1: products
  logic                      v1_r;
  logic signed [2*FW-1:0]    sq1_r;
  logic signed [2*IW-1:0]    bc1_r;
  logic signed [FW-1:0]      diff1_r, tr1_r;
  logic signed [IW-1:0]      c1_r;
  logic signed [FW-1:0]      diff1_nxt;

  assign diff1_nxt = FW'(a0_r) - FW'(d0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    sq1_r   <= diff1_nxt * diff1_nxt;
    bc1_r   <= b0_r * c0_r;
    diff1_r <= diff1_nxt;
    tr1_r   <= FW'(a0_r) + FW'(d0_r);
    c1_r    <= c0_r;
  end

  // ---- stage 2: discriminant
  logic                  v2_r;
  logic [AW-1:0]         rad2_r;
  eig_pkg::root_side_t   side2_r;
  logic signed [XW-1:0]  disc2;

  assign disc2 = XW'(sq1_r) + (XW'(bc1_r) <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    rad2_r        <= disc2[XW-1] ? '0 : disc2[AW-1:0];
    side2_r.diff  <= diff1_r;
    side2_r.tr    <= tr1_r;
    side2_r.neg   <= disc2[XW-1];
    side2_r.czero <= (c1_r == '0);
    side2_r.c     <= c1_r;
  end

  // ---- root: one bit per stage
  logic [AW-1:0]        rad_r  [RW];
  logic [MW-1:0]        rem_r  [RW];
  logic [RW-1:0]        root_r [RW];
  eig_pkg::root_side_t  rside_r[RW];
  logic [RW-1:0]        rv_r;

  for (genvar i = 0; i < RW; i++) begin : g_root
    logic [AW-1:0]       rad_in;
    logic [MW-1:0]       rem_in;
    logic [RW-1:0]       root_in;
    eig_pkg::root_side_t side_in;
    logic                v_in;
    logic [MW-1:0]       rem_t;
    logic [MW-1:0]       trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad2_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side2_r;
      assign v_in    = v2_r;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = rside_r[i-1];
      assign v_in    = rv_r[i-1];
    end

    assign rem_t = {rem_in[MW-3:0], rad_in[AW-1:AW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[i] <= 1'b0;
      end else begin
        rv_r[i] <= v_in;
      end
      rad_r[i]   <= {rad_in[AW-3:0], 2'b00};
      rem_r[i]   <= ge ? (rem_t - trial) : rem_t;
      root_r[i]  <= {root_in[RW-2:0], ge};
      rside_r[i] <= side_in;
    end
  end

  // ---- eigenvalues and vector numerators
  eig_pkg::root_side_t  rs;
  logic signed [NW-1:0] s_ext, tr_ext, df_ext, sl, sh;
  logic                 v3_r;
  eig_pkg::div_side_t   dside3_r;
  logic signed [NW-1:0] nlo3_r, nhi3_r;
  logic signed [IW-1:0] c3_r;

  assign rs     = rside_r[RW-1];
  assign s_ext  = $signed({{(NW-RW){1'b0}}, root_r[RW-1]});
  assign tr_ext = NW'(rs.tr);
  assign df_ext = NW'(rs.diff);
  assign sl     = tr_ext - s_ext;
  assign sh     = tr_ext + s_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= rv_r[RW-1];
    end
    dside3_r.lo    <= sl[LW:1];
    dside3_r.hi    <= sh[LW:1];
    dside3_r.neg   <= rs.neg;
    dside3_r.czero <= rs.czero;
    nlo3_r         <= df_ext - s_ext;
    nhi3_r         <= df_ext + s_ext;
    c3_r           <= rs.c;
  end

  // ---- dividers and matching delay line
  logic signed [eig_pkg::VEC_W-1:0] qlo, qhi;
  logic                             satlo, sathi;

  eig_div u_div_lo (.clk(clk), .num(nlo3_r), .den(c3_r), .q(qlo), .sat(satlo));
  eig_div u_div_hi (.clk(clk), .num(nhi3_r), .den(c3_r), .q(qhi), .sat(sathi));

  eig_pkg::div_side_t dl_r [DL];
  logic [DL-1:0]      dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= {dv_r[DL-2:0], v3_r};
    end
    dl_r[0] <= dside3_r;
    for (int k = 1; k < DL; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  // ---- result word
  eig_pkg::div_side_t fin;
  eig_pkg::status_t   st;

  assign fin = dl_r[DL-1];

  always_comb begin
    out_lambda_low    = fin.lo;
    out_lambda_high   = fin.hi;
    out_vector_low_x  = qlo;
    out_vector_high_x = qhi;
    st                = eig_pkg::ST_OK;
    if (fin.neg) begin
      out_lambda_low    = '0;
      out_lambda_high   = '0;
      out_vector_low_x  = '0;
      out_vector_high_x = '0;
      st                = eig_pkg::ST_COMPLEX;
    end else if (fin.czero) begin
      out_vector_low_x  = '0;
      out_vector_high_x = '0;
      st                = eig_pkg::ST_CZERO;
    end else if (satlo || sathi) begin
      st = eig_pkg::ST_SAT;
    end
  end

  assign out_status = st;
  assign out_valid  = dv_r[DL-1];

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, eig_pkg::LATENCY))
    else $error("result word without matching start");

  a_cplx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == eig_pkg::ST_COMPLEX) |->
      (out_lambda_low == '0 && out_lambda_high == '0 &&
       out_vector_low_x == '0 && out_vector_high_x == '0))
    else $error("complex word carries nonzero values");

  a_czero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == eig_pkg::ST_CZERO) |->
      (out_vector_low_x == '0 && out_vector_high_x == '0))
    else $error("zero divisor word carries nonzero vectors");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != eig_pkg::ST_COMPLEX) |->
      (out_lambda_low <= out_lambda_high))
    else $error("eigenvalues out of order");
`endif

endmodule

@@ tb/eigen_2x2_closed_form_test.sv @@
// Testbench for eigen_2x2_closed_form: drives matrices through the start/busy
// handshake and checks every out_valid word against an in-bench predictor.
// Depends on eig_pkg and the eigen_2x2_closed_form RTL.
module eigen_2x2_closed_form_test;

  localparam int WATCHDOG = 20000;
  localparam int NUM_RANDOM = 1900;
  localparam int NUM_DIRECTED = 14;

  typedef struct packed {
    logic signed [eig_pkg::LAM_W-1:0] lo;
    logic signed [eig_pkg::LAM_W-1:0] hi;
    logic signed [eig_pkg::VEC_W-1:0] vlo;
    logic signed [eig_pkg::VEC_W-1:0] vhi;
    eig_pkg::status_t                 st;
  } eig_word_t;

  typedef struct {
    logic signed [eig_pkg::IN_W-1:0] a, b, c, d;
    bit                              known;
    eig_word_t                       res;
  } mat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [eig_pkg::IN_W-1:0] in_a = '0, in_b = '0, in_c = '0, in_d = '0;
  logic out_valid;
  logic signed [eig_pkg::LAM_W-1:0] out_lo, out_hi;
  logic signed [eig_pkg::VEC_W-1:0] out_vlo, out_vhi;
  logic [1:0] out_st;

  eig_word_t eig_pending[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle = 0;
  mat_row_t stim_table[NUM_DIRECTED];

  eigen_2x2_closed_form DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_top_left(in_a), .in_top_right(in_b),
    .in_bottom_left(in_c), .in_bottom_right(in_d),
    .out_valid(out_valid), .out_lambda_low(out_lo), .out_lambda_high(out_hi),
    .out_vector_low_x(out_vlo), .out_vector_high_x(out_vhi), .out_status(out_st)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint isqrt_floor(longint v);
    longint r;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      if ((r + (64'sd1 <<< k)) * (r + (64'sd1 <<< k)) <= v) r = r + (64'sd1 <<< k);
    end
    return r;
  endfunction

  function automatic longint eig_quot(longint num, longint c, ref bit sat);
    longint q;
    q = (num * 256) / (2 * c);
    if (q > 64'sd8388607) begin
      sat = 1'b1;
      return 64'sd8388607;
    end
    if (q < -64'sd8388608) begin
      sat = 1'b1;
      return -64'sd8388608;
    end
    return q;
  endfunction

  function automatic eig_word_t eigen_predict(logic signed [eig_pkg::IN_W-1:0] a,
      logic signed [eig_pkg::IN_W-1:0] b, logic signed [eig_pkg::IN_W-1:0] c,
      logic signed [eig_pkg::IN_W-1:0] d);
    eig_word_t w;
    longint diff, disc, s, tr;
    bit sat;
    w = '0;
    w.st = eig_pkg::ST_OK;
    diff = longint'(a) - longint'(d);
    disc = diff * diff + 4 * longint'(b) * longint'(c);
    if (disc < 0) begin
      w.st = eig_pkg::ST_COMPLEX;
    end else begin
      s = isqrt_floor(disc);
      tr = longint'(a) + longint'(d);
      w.lo = eig_pkg::LAM_W'((tr - s) >>> 1);
      w.hi = eig_pkg::LAM_W'((tr + s) >>> 1);
      if (c == 0) begin
        w.st = eig_pkg::ST_CZERO;
      end else begin
        sat = 1'b0;
        w.vlo = eig_pkg::VEC_W'(eig_quot(diff - s, longint'(c), sat));
        w.vhi = eig_pkg::VEC_W'(eig_quot(diff + s, longint'(c), sat));
        if (sat) w.st = eig_pkg::ST_SAT;
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_matrix(logic signed [eig_pkg::IN_W-1:0] a,
      logic signed [eig_pkg::IN_W-1:0] b, logic signed [eig_pkg::IN_W-1:0] c,
      logic signed [eig_pkg::IN_W-1:0] d, int gap_pct);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_a <= a;
    in_b <= b;
    in_c <= c;
    in_d <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    eig_pending.push_back(eigen_predict(a, b, c, d));
  endtask

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    eig_word_t w;
    if (rst_n && out_valid) begin
      if (eig_pending.size() == 0) begin
        report_mismatch("unexpected word, status", out_st, 0);
      end else begin
        w = eig_pending.pop_front();
        if (out_lo !== w.lo) report_mismatch("lambda_low", out_lo, w.lo);
        if (out_hi !== w.hi) report_mismatch("lambda_high", out_hi, w.hi);
        if (out_vlo !== w.vlo) report_mismatch("vector_low_x", out_vlo, w.vlo);
        if (out_vhi !== w.vhi) report_mismatch("vector_high_x", out_vhi, w.vhi);
        if (out_st !== w.st) report_mismatch("status", out_st, w.st);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d words pending", eig_pending.size());
      $display("eigen_2x2_closed_form: mismatch");
      $finish;
    end
  end

  function automatic logic signed [eig_pkg::IN_W-1:0] rand_entry(int mode);
    case (mode)
      0: return eig_pkg::IN_W'($urandom);
      1: return eig_pkg::IN_W'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  initial begin
    int mode;
    eig_word_t w0;
    // typed-in rows: zero matrix and complex cases read straight off the rules
    w0 = '0;
    w0.st = eig_pkg::ST_CZERO;
    stim_table[0] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, w0};
    w0 = '0;
    w0.st = eig_pkg::ST_COMPLEX;
    stim_table[1] = '{16'sd0, 16'sd256, -16'sd256, 16'sd0, 1'b1, w0};
    stim_table[2] = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, w0};
    stim_table[3] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, w0};
    stim_table[4] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, w0};
    stim_table[5] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, w0};
    stim_table[6] = '{16'sh7fff, 16'sh0, 16'sh1, 16'sh8000, 1'b0, w0};
    stim_table[7] = '{16'sh8000, 16'sh0, -16'sd1, 16'sh7fff, 1'b0, w0};
    stim_table[8] = '{16'sd512, 16'sd256, 16'sd256, 16'sd512, 1'b0, w0};
    stim_table[9] = '{-16'sd768, 16'sd100, 16'sd0, 16'sd300, 1'b0, w0};
    stim_table[10] = '{16'sd256, -16'sd1, 16'sd1, 16'sd256, 1'b0, w0};
    stim_table[11] = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, w0};
    stim_table[12] = '{16'sd1000, 16'sd3, -16'sd7, -16'sd1000, 1'b0, w0};
    stim_table[13] = '{16'sd255, 16'sh7fff, 16'sh7fff, 16'sd0, 1'b0, w0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      send_matrix(stim_table[i].a, stim_table[i].b, stim_table[i].c, stim_table[i].d, 0);
      if (stim_table[i].known) eig_pending[$] = stim_table[i].res;
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      case ((n / 100) % 4)
        0: sender_idle = 0;
        1: sender_idle = 48;
        2: sender_idle = 0;
        default: sender_idle = 26;
      endcase
      mode = $urandom_range(9);
      if (mode < 5) send_matrix(rand_entry(0), rand_entry(0), rand_entry(0), rand_entry(0),
                                sender_idle);
      else if (mode < 8) send_matrix(rand_entry(1), rand_entry(1), rand_entry(1),
                                     rand_entry(1), sender_idle);
      else send_matrix(rand_entry($urandom_range(3)), rand_entry($urandom_range(3)),
                       rand_entry($urandom_range(3)), rand_entry($urandom_range(3)),
                       sender_idle);
    end
    start <= 1'b0;

    while (eig_pending.size() != 0) @(posedge clk);
    repeat (eig_pkg::LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("eigen_2x2_closed_form: match");
    else $display("eigen_2x2_closed_form: mismatch");
    $finish;
  end
endmodule
